/* hw/rtl/qmr_pkg.sv */
package qmr_pkg;

    // Table and position limits
    localparam int MAX_CHANNELS    = 4096;
    localparam int CH_W            = $clog2(MAX_CHANNELS);
    localparam int CHCNT_W         = $clog2(MAX_CHANNELS + 1);
    localparam int LOAD_CH_W       = 12;
    localparam int INNER_W         = 24;
    localparam int INNER_CFG_W     = 25;
    localparam int INNER_LIMIT     = 1 << INNER_W;

    // Fixed-point scale
    localparam int SCALE_W         = 32;
    localparam int SCALE_FRAC_BITS = 24;

    // Datapath widths
    localparam int ZP_W            = 9;
    localparam int DIFF_W          = 11;
    localparam int PROD_W          = 2 * DIFF_W;
    localparam int MAG_W           = 18;
    localparam int SPROD_W         = MAG_W + SCALE_W;
    localparam int Q_W             = SPROD_W - SCALE_FRAC_BITS + 1;
    localparam int V_W             = Q_W + 2;

    // Configuration register indexes
    localparam logic [3:0] REG_LAYOUT      = 4'd0;
    localparam logic [3:0] REG_DATA_SIGNED = 4'd1;
    localparam logic [3:0] REG_SCALE       = 4'd2;
    localparam logic [3:0] REG_A_ZERO      = 4'd3;
    localparam logic [3:0] REG_B_ZERO      = 4'd4;
    localparam logic [3:0] REG_Y_ZERO      = 4'd5;
    localparam logic [3:0] REG_CHANNELS    = 4'd6;
    localparam logic [3:0] REG_INNER_SIZE  = 4'd7;

    // Layout codes
    localparam logic [1:0] LAY_SAME   = 2'd0;
    localparam logic [1:0] LAY_CHMAJ  = 2'd1;
    localparam logic [1:0] LAY_CHLAST = 2'd2;

    // Request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_ELEM = 1'b1;

    typedef struct packed {
        logic [1:0]             layout;
        logic                   data_signed;
        logic [SCALE_W-1:0]     scale;
        logic [ZP_W-1:0]        a_zero;
        logic [ZP_W-1:0]        b_zero;
        logic [ZP_W-1:0]        y_zero;
        logic [CHCNT_W-1:0]     channels;
        logic [INNER_CFG_W-1:0] inner_size;
    } t_cfg;

endpackage

/* hw/rtl/qmr_chan.sv */
module qmr_chan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  qmr_pkg::t_cfg                i_cfg,
    input  logic                         i_cfg_wr,
    input  logic                         i_load,
    input  logic [qmr_pkg::LOAD_CH_W-1:0] i_load_ch,
    input  logic [7:0]                   i_load_data,
    input  logic                         i_elem,
    output logic [7:0]                   o_rd_data
);

    logic [7:0]                           r_table [qmr_pkg::MAX_CHANNELS];
    logic [7:0]                           r_rd_data;
    logic [qmr_pkg::CH_W-1:0]             r_chan_pos;
    logic [qmr_pkg::CH_W-1:0]             n_chan_pos;
    logic [qmr_pkg::INNER_W-1:0]          r_inner_pos;
    logic [qmr_pkg::INNER_W-1:0]          n_inner_pos;
    logic [qmr_pkg::CHCNT_W-1:0]          eff_chans;
    logic [qmr_pkg::INNER_CFG_W-1:0]      eff_inner;
    logic [qmr_pkg::CH_W-1:0]             cur_pos;
    logic [qmr_pkg::CHCNT_W-1:0]          chan_inc;
    logic [qmr_pkg::INNER_CFG_W-1:0]      inner_inc;
    logic                                 chan_wrap;
    logic                                 uses_table;

    // Effective channel count and run length
    always_comb begin
        if (i_cfg.channels == '0) begin
            eff_chans = qmr_pkg::CHCNT_W'(1);
        end else if (i_cfg.channels > qmr_pkg::CHCNT_W'(qmr_pkg::MAX_CHANNELS)) begin
            eff_chans = qmr_pkg::CHCNT_W'(qmr_pkg::MAX_CHANNELS);
        end else begin
            eff_chans = i_cfg.channels;
        end
        if (i_cfg.inner_size == '0) begin
            eff_inner = qmr_pkg::INNER_CFG_W'(1);
        end else if (i_cfg.inner_size > qmr_pkg::INNER_CFG_W'(qmr_pkg::INNER_LIMIT)) begin
            eff_inner = qmr_pkg::INNER_CFG_W'(qmr_pkg::INNER_LIMIT);
        end else begin
            eff_inner = i_cfg.inner_size;
        end
    end

    // Position update for the table layouts
    always_comb begin
        cur_pos     = ({1'b0, r_chan_pos} >= eff_chans) ? '0 : r_chan_pos;
        chan_inc    = {1'b0, cur_pos} + qmr_pkg::CHCNT_W'(1);
        chan_wrap   = chan_inc >= eff_chans;
        inner_inc   = {1'b0, r_inner_pos} + qmr_pkg::INNER_CFG_W'(1);
        uses_table  = (i_cfg.layout == qmr_pkg::LAY_CHMAJ) ||
                      (i_cfg.layout == qmr_pkg::LAY_CHLAST);
        n_chan_pos  = r_chan_pos;
        n_inner_pos = r_inner_pos;
        case (i_cfg.layout)
            qmr_pkg::LAY_CHMAJ: begin
                if (inner_inc >= eff_inner) begin
                    n_inner_pos = '0;
                    n_chan_pos  = chan_wrap ? '0 : chan_inc[qmr_pkg::CH_W-1:0];
                end else begin
                    n_inner_pos = inner_inc[qmr_pkg::INNER_W-1:0];
                    n_chan_pos  = cur_pos;
                end
            end
            qmr_pkg::LAY_CHLAST: begin
                n_chan_pos = chan_wrap ? '0 : chan_inc[qmr_pkg::CH_W-1:0];
            end
            default: begin
                n_chan_pos  = r_chan_pos;
                n_inner_pos = r_inner_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr) begin
            r_chan_pos  <= '0;
            r_inner_pos <= '0;
        end else if (i_elem && uses_table) begin
            r_chan_pos  <= n_chan_pos;
            r_inner_pos <= n_inner_pos;
        end
    end

    // Channel table: one write or one read per cycle, registered read
    always_ff @(posedge i_clk) begin
        if (i_load && (32'(i_load_ch) < qmr_pkg::MAX_CHANNELS)) begin
            r_table[qmr_pkg::CH_W'(i_load_ch)] <= i_load_data;
        end
        if (i_elem) begin
            r_rd_data <= r_table[cur_pos];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/qmr_math.sv */
module qmr_math (
    input  logic          i_clk,
    input  logic          i_start,
    input  qmr_pkg::t_cfg i_cfg,
    input  logic [7:0]    i_a,
    input  logic [7:0]    i_b,
    output logic [7:0]    o_y
);

    logic signed [qmr_pkg::DIFF_W-1:0]  da;
    logic signed [qmr_pkg::DIFF_W-1:0]  db;
    logic signed [qmr_pkg::PROD_W-1:0]  r_prod;
    logic [qmr_pkg::PROD_W-1:0]         mag_full;
    logic                               r_neg;
    logic [qmr_pkg::SPROD_W-1:0]        r_sprod;
    logic [qmr_pkg::Q_W-1:0]            q;
    logic [qmr_pkg::SCALE_FRAC_BITS-1:0] rem;
    logic [qmr_pkg::SCALE_FRAC_BITS-1:0] half;
    logic                               round_up;
    logic signed [qmr_pkg::V_W-1:0]     v;
    logic signed [qmr_pkg::V_W-1:0]     lo;
    logic signed [qmr_pkg::V_W-1:0]     hi;

    // Zero-point offsets, bytes signed or unsigned per config
    always_comb begin
        da = $signed({{(qmr_pkg::DIFF_W-8){i_cfg.data_signed & i_a[7]}}, i_a}) -
             $signed({{(qmr_pkg::DIFF_W-qmr_pkg::ZP_W){i_cfg.a_zero[qmr_pkg::ZP_W-1]}},
                      i_cfg.a_zero});
        db = $signed({{(qmr_pkg::DIFF_W-8){i_cfg.data_signed & i_b[7]}}, i_b}) -
             $signed({{(qmr_pkg::DIFF_W-qmr_pkg::ZP_W){i_cfg.b_zero[qmr_pkg::ZP_W-1]}},
                      i_cfg.b_zero});
    end

    // Stage 1: operand product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= da * db;
        end
    end

    // Stage 2: magnitude times scale, sign kept aside
    assign mag_full = r_prod[qmr_pkg::PROD_W-1] ? 
                      qmr_pkg::PROD_W'(-r_prod) : qmr_pkg::PROD_W'(r_prod);

    always_ff @(posedge i_clk) begin
        r_neg   <= r_prod[qmr_pkg::PROD_W-1];
        r_sprod <= qmr_pkg::SPROD_W'(mag_full[qmr_pkg::MAG_W-1:0]) *
                   qmr_pkg::SPROD_W'(i_cfg.scale);
    end

    // Round half to even, restore sign, add output zero point, clamp
    always_comb begin
        q        = {1'b0, r_sprod[qmr_pkg::SPROD_W-1:qmr_pkg::SCALE_FRAC_BITS]};
        rem      = r_sprod[qmr_pkg::SCALE_FRAC_BITS-1:0];
        half     = {1'b1, {(qmr_pkg::SCALE_FRAC_BITS-1){1'b0}}};
        round_up = (rem > half) || ((rem == half) && q[0]);
        q        = q + qmr_pkg::Q_W'(round_up);
        v        = r_neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        v        = v + $signed({{(qmr_pkg::V_W-qmr_pkg::ZP_W){i_cfg.y_zero[qmr_pkg::ZP_W-1]}},
                               i_cfg.y_zero});
        lo       = i_cfg.data_signed ? -qmr_pkg::V_W'(128) : '0;
        hi       = i_cfg.data_signed ? qmr_pkg::V_W'(127) : qmr_pkg::V_W'(255);
        if (v < lo) begin
            v = lo;
        end else if (v > hi) begin
            v = hi;
        end
        o_y = v[7:0];
    end

endmodule

/* hw/rtl/quantized_multiply_requantize_top.sv */
// Channel   Dir  Transaction                       Payload
// s_axis    in   one load or one element           tuser req_type, tdata a/b/load_channel
// m_axis    out  one result byte per element       tdata y_value
// cfg       in   one register write                index, 32-bit data
//
// A load is taken without leaving the idle state. An element passes through table read, product,
// scale multiply, round and clamp into the output register before the next item is taken.
// A finished result waits in the output register while the next item is taken;
// the round/clamp step holds only if that register is still full.
// Reset is synchronous: registers to defaults, positions to zero. The channel
// table has no reset and must be loaded before a per-channel layout reads it.
module quantized_multiply_requantize_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [7:0] a_value, [15:8] b_value, [27:16] load_channel
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] y_value
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    qmr_pkg::t_cfg r_cfg;
    logic          cfg_wr;
    logic          cfg_hit;
    logic          in_acc;
    logic          elem_acc;
    logic          load_acc;
    logic [7:0]    r_a;
    logic [7:0]    r_b;
    logic [7:0]    tbl_b;
    logic [7:0]    b_sel;
    logic [7:0]    y_res;
    logic          out_free;
    logic          r_out_valid;
    logic [7:0]    r_out_data;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign elem_acc = in_acc && (s_axis_tuser == qmr_pkg::REQ_ELEM);
    assign load_acc = in_acc && (s_axis_tuser == qmr_pkg::REQ_LOAD);
    assign cfg_wr   = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = (r_state == ST_IDLE);

    // Configuration registers
    always_comb begin
        cfg_hit = 1'b1;
        case (i_cfg_index)
            qmr_pkg::REG_LAYOUT, qmr_pkg::REG_DATA_SIGNED, qmr_pkg::REG_SCALE,
            qmr_pkg::REG_A_ZERO, qmr_pkg::REG_B_ZERO, qmr_pkg::REG_Y_ZERO,
            qmr_pkg::REG_CHANNELS, qmr_pkg::REG_INNER_SIZE: cfg_hit = 1'b1;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.layout      <= qmr_pkg::LAY_SAME;
            r_cfg.data_signed <= 1'b0;
            r_cfg.scale       <= qmr_pkg::SCALE_W'(1) << qmr_pkg::SCALE_FRAC_BITS;
            r_cfg.a_zero      <= '0;
            r_cfg.b_zero      <= '0;
            r_cfg.y_zero      <= '0;
            r_cfg.channels    <= qmr_pkg::CHCNT_W'(1);
            r_cfg.inner_size  <= qmr_pkg::INNER_CFG_W'(1);
        end else if (cfg_wr) begin
            case (i_cfg_index)
                qmr_pkg::REG_LAYOUT:      r_cfg.layout      <= i_cfg_data[1:0];
                qmr_pkg::REG_DATA_SIGNED: r_cfg.data_signed <= i_cfg_data[0];
                qmr_pkg::REG_SCALE:       r_cfg.scale       <= i_cfg_data;
                qmr_pkg::REG_A_ZERO:      r_cfg.a_zero      <= i_cfg_data[qmr_pkg::ZP_W-1:0];
                qmr_pkg::REG_B_ZERO:      r_cfg.b_zero      <= i_cfg_data[qmr_pkg::ZP_W-1:0];
                qmr_pkg::REG_Y_ZERO:      r_cfg.y_zero      <= i_cfg_data[qmr_pkg::ZP_W-1:0];
                qmr_pkg::REG_CHANNELS:    r_cfg.channels    <= i_cfg_data[qmr_pkg::CHCNT_W-1:0];
                qmr_pkg::REG_INNER_SIZE:
                    r_cfg.inner_size <= i_cfg_data[qmr_pkg::INNER_CFG_W-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // Element operands held for the datapath
    always_ff @(posedge i_clk) begin
        if (elem_acc) begin
            r_a <= s_axis_tdata[7:0];
            r_b <= s_axis_tdata[15:8];
        end
    end

    qmr_chan u_chan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cfg_wr    (cfg_wr && cfg_hit),
        .i_load      (load_acc),
        .i_load_ch   (s_axis_tdata[27:16]),
        .i_load_data (s_axis_tdata[15:8]),
        .i_elem      (elem_acc),
        .o_rd_data   (tbl_b)
    );

    assign b_sel = ((r_cfg.layout == qmr_pkg::LAY_CHMAJ) ||
                    (r_cfg.layout == qmr_pkg::LAY_CHLAST)) ? tbl_b : r_b;

    qmr_math u_math (
        .i_clk   (i_clk),
        .i_start (r_state == ST_READ),
        .i_cfg   (r_cfg),
        .i_a     (r_a),
        .i_b     (b_sel),
        .o_y     (y_res)
    );

    // Item sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (elem_acc) n_state = ST_READ;
            ST_READ: n_state = ST_MUL;
            ST_MUL:  n_state = ST_FIN;
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && out_free) begin
            r_out_data <= y_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* tb/tb_quantized_multiply_requantize_top.sv */
module tb_quantized_multiply_requantize_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned t_u64;

    localparam int DRAIN_CYCLES = 16;   // element latency plus margin
    localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
    localparam int RANDOM_ITEMS = 1450;
    localparam int PHASE_MAX    = 150;  // longest random phase
    // Positions restart at each defined register write and no phase runs longer
    // than this, so per-channel reads only land on these loaded slots
    localparam int TABLE_FILL   = PHASE_MAX + 16;

    // Index with no register behind it: write is dropped, positions kept
    localparam logic [3:0] REG_NONE  = 4'd15;
    // Unassigned layout code, behaves as same shape
    localparam logic [1:0] LAY_ALIAS = 2'd3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;     // [7:0] a_value, [15:8] b_value, [27:16] load_channel
    logic        s_axis_tuser  = 1'b0;   // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [7:0] y_value
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;

    quantized_multiply_requantize_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Mirror of the block: registers, channel table, position counters
    qmr_pkg::t_cfg cur;
    logic [7:0]    chan_table [qmr_pkg::MAX_CHANNELS];
    int            inner_pos;
    int            chan_pos;
    logic [7:0]    pending_y [$];

    // Run statistics
    int errors    = 0;
    int n_checked = 0;
    int n_loads   = 0;
    int n_writes  = 0;
    int n_phases  = 0;

    // Sender and receiver pacing
    int burst_left  = 0;
    int tx_gap_max  = 0;
    bit rx_stall_en = 1'b0;
    int hold_asked  = 0;
    int hold_taken  = 0;
    int hold_left   = 0;
    int rx_run_left = 0;
    bit rx_run_on   = 1'b1;

    function automatic qmr_pkg::t_cfg default_cfg();
        qmr_pkg::t_cfg c;
        c.layout      = qmr_pkg::LAY_SAME;
        c.data_signed = 1'b0;
        c.scale       = 32'd1 << qmr_pkg::SCALE_FRAC_BITS;
        c.a_zero      = '0;
        c.b_zero      = '0;
        c.y_zero      = '0;
        c.channels    = qmr_pkg::CHCNT_W'(1);
        c.inner_size  = qmr_pkg::INNER_CFG_W'(1);
        return c;
    endfunction

    // Register write seen by the mirror; unknown indexes change nothing
    function automatic void apply_reg(logic [3:0] idx, logic [31:0] data);
        case (idx)
            qmr_pkg::REG_LAYOUT:      cur.layout      = data[1:0];
            qmr_pkg::REG_DATA_SIGNED: cur.data_signed = data[0];
            qmr_pkg::REG_SCALE:       cur.scale       = data;
            qmr_pkg::REG_A_ZERO:      cur.a_zero      = data[qmr_pkg::ZP_W-1:0];
            qmr_pkg::REG_B_ZERO:      cur.b_zero      = data[qmr_pkg::ZP_W-1:0];
            qmr_pkg::REG_Y_ZERO:      cur.y_zero      = data[qmr_pkg::ZP_W-1:0];
            qmr_pkg::REG_CHANNELS:    cur.channels    = data[qmr_pkg::CHCNT_W-1:0];
            qmr_pkg::REG_INNER_SIZE:  cur.inner_size  = data[qmr_pkg::INNER_CFG_W-1:0];
            default:                  return;
        endcase
        inner_pos = 0;
        chan_pos  = 0;
    endfunction

    function automatic int byte_val(logic [7:0] x);
        return cur.data_signed ? int'($signed(x)) : int'(x);
    endfunction

    // Exact product times fixed-point scale, round half to even, offset, clamp
    function automatic logic [7:0] compute_y(int da, int db);
        longint prod;
        bit     neg;
        t_u64   absp;
        t_u64   mag;
        t_u64   q;
        t_u64   rem;
        t_u64   half;
        longint v;
        longint lo;
        longint hi;
        prod = longint'(da) * longint'(db);
        neg  = prod < 0;
        absp = neg ? -prod : prod;
        mag  = absp * t_u64'(cur.scale);
        q    = mag >> qmr_pkg::SCALE_FRAC_BITS;
        rem  = mag & ((t_u64'(1) << qmr_pkg::SCALE_FRAC_BITS) - 1);
        half = t_u64'(1) << (qmr_pkg::SCALE_FRAC_BITS - 1);
        if (rem > half || (rem == half && q[0]))
            q++;
        v  = neg ? -longint'(q) : longint'(q);
        v  = v + longint'($signed(cur.y_zero));
        lo = cur.data_signed ? -128 : 0;
        hi = cur.data_signed ? 127 : 255;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v[7:0];
    endfunction

    // One element: pick b, advance the channel position, queue the result
    function automatic void step_element(logic [7:0] a_raw, logic [7:0] b_raw);
        int chans;
        int inner_lim;
        int b;
        chans     = (cur.channels == 0) ? 1 :
                    (cur.channels > qmr_pkg::MAX_CHANNELS) ? qmr_pkg::MAX_CHANNELS :
                    int'(cur.channels);
        inner_lim = (cur.inner_size == 0) ? 1 :
                    (cur.inner_size > qmr_pkg::INNER_LIMIT) ? qmr_pkg::INNER_LIMIT :
                    int'(cur.inner_size);
        if (chan_pos >= chans)
            chan_pos = 0;
        case (cur.layout)
            qmr_pkg::LAY_CHMAJ: begin
                b = byte_val(chan_table[chan_pos]);
                inner_pos++;
                if (inner_pos >= inner_lim) begin
                    inner_pos = 0;
                    chan_pos++;
                    if (chan_pos >= chans)
                        chan_pos = 0;
                end
            end
            qmr_pkg::LAY_CHLAST: begin
                b = byte_val(chan_table[chan_pos]);
                chan_pos++;
                if (chan_pos >= chans)
                    chan_pos = 0;
            end
            default: b = byte_val(b_raw);
        endcase
        pending_y.push_back(compute_y(byte_val(a_raw) - int'($signed(cur.a_zero)),
                                      b - int'($signed(cur.b_zero))));
    endfunction

    // Offer one input transaction, pacing the sender in bursts
    task automatic issue_item(input logic kind, input logic [7:0] a, input logic [7:0] b,
                              input logic [11:0] slot);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0, slot, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == qmr_pkg::REQ_LOAD) begin
            chan_table[slot] = b;
            n_loads++;
        end else begin
            step_element(a, b);
        end
    endtask

    task automatic elem(input logic [7:0] a, input logic [7:0] b);
        issue_item(qmr_pkg::REQ_ELEM, a, b, 12'($urandom()));
    endtask

    // Register write transaction; the caller drops valid after the last one
    task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        n_writes++;
    endtask

    function automatic logic [31:0] with_junk(int w, logic [31:0] v, bit junk);
        return junk ? ((32'($urandom()) << w) | v) : v;
    endfunction

    task automatic configure(input qmr_pkg::t_cfg c, input bit junk);
        write_reg(qmr_pkg::REG_LAYOUT,      with_junk(2, 32'(c.layout), junk));
        write_reg(qmr_pkg::REG_DATA_SIGNED, with_junk(1, 32'(c.data_signed), junk));
        write_reg(qmr_pkg::REG_SCALE,       c.scale);
        write_reg(qmr_pkg::REG_A_ZERO,      with_junk(qmr_pkg::ZP_W, 32'(c.a_zero), junk));
        write_reg(qmr_pkg::REG_B_ZERO,      with_junk(qmr_pkg::ZP_W, 32'(c.b_zero), junk));
        write_reg(qmr_pkg::REG_Y_ZERO,      with_junk(qmr_pkg::ZP_W, 32'(c.y_zero), junk));
        write_reg(qmr_pkg::REG_CHANNELS,
                  with_junk(qmr_pkg::CHCNT_W, 32'(c.channels), junk));
        write_reg(qmr_pkg::REG_INNER_SIZE,
                  with_junk(qmr_pkg::INNER_CFG_W, 32'(c.inner_size), junk));
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering, let every expected result drain, then the pipeline
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_y.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Result-side ready: long hold-offs on request, else always ready or random on/off runs
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_taken != hold_asked) begin
            hold_taken++;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (!rx_stall_en) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (rx_run_left == 0) begin
                rx_run_on   = !rx_run_on;
                rx_run_left = rx_run_on ? $urandom_range(1, 10) : $urandom_range(1, 5);
            end
            rx_run_left--;
            m_axis_tready <= rx_run_on;
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : check_y
        logic [7:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_y.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %02h",
                         $time, m_axis_tdata);
            end else begin
                want = pending_y.pop_front();
                n_checked++;
                if (m_axis_tdata !== want) begin
                    errors++;
                    $display("%0t: y_value mismatch, expected %02h, actual %02h",
                             $time, want, m_axis_tdata);
                end
            end
        end
    end

    // Reset defaults: same shape, unsigned, scale 1.0
    task automatic test_defaults();
        elem(8'h00, 8'h00);
        elem(8'hFF, 8'hFF);
        elem(8'd3, 8'd5);
        elem(8'd15, 8'd17);
    endtask

    // Load the low table slots so per-channel reads always hit written entries
    task automatic test_table_fill();
        wait_idle();
        for (int i = 0; i < TABLE_FILL; i++)
            issue_item(qmr_pkg::REQ_LOAD, 8'($urandom()), 8'($urandom()), 12'(i));
    endtask

    // Ties at exactly one half, signed and unsigned clamps, zero-point extremes
    task automatic test_round_clamp();
        qmr_pkg::t_cfg c;
        wait_idle();
        c = default_cfg();
        c.data_signed = 1'b1;
        c.scale       = 32'd1 << (qmr_pkg::SCALE_FRAC_BITS - 1);
        configure(c, 1'b0);
        elem(8'd3, 8'd1);       // 1.5 -> 2
        elem(8'd5, 8'd1);       // 2.5 -> 2
        elem(8'hFD, 8'd1);      // -1.5 -> -2
        elem(8'hFB, 8'd1);      // -2.5 -> -2
        elem(8'h80, 8'h80);     // clamps high
        elem(8'h7F, 8'h80);     // clamps low
        wait_idle();
        c.data_signed = 1'b0;
        c.a_zero      = 9'h0FF;
        c.b_zero      = 9'h100; // most negative zero point
        c.y_zero      = 9'h0FF;
        configure(c, 1'b1);
        elem(8'h00, 8'hFF);
        elem(8'hFF, 8'h00);
    endtask

    // Layout alias, zero inner size, zero channels, dropped register write
    task automatic test_layouts();
        qmr_pkg::t_cfg c;
        wait_idle();
        c = default_cfg();
        c.layout = LAY_ALIAS;
        configure(c, 1'b0);
        elem(8'd2, 8'd9);
        elem(8'd7, 8'd3);
        wait_idle();
        c.layout     = qmr_pkg::LAY_CHMAJ;
        c.channels   = qmr_pkg::CHCNT_W'(3);
        c.inner_size = '0;
        configure(c, 1'b0);
        repeat (3) elem(8'd1, 8'h00);
        wait_idle();
        c.layout   = qmr_pkg::LAY_CHLAST;
        c.channels = '0;
        configure(c, 1'b0);
        repeat (2) elem(8'd1, 8'h00);
        wait_idle();
        c.channels = qmr_pkg::CHCNT_W'(4);
        configure(c, 1'b0);
        repeat (2) elem(8'd1, 8'h00);
        wait_idle();
        write_reg(REG_NONE, $urandom());
        i_cfg_valid <= 1'b0;
        repeat (2) elem(8'd1, 8'h00);   // positions kept
        wait_idle();
        write_reg(qmr_pkg::REG_SCALE, c.scale);
        i_cfg_valid <= 1'b0;
        elem(8'd1, 8'h00);              // positions cleared
    endtask

    // Channel count and run length above their limits
    task automatic test_channel_limit();
        qmr_pkg::t_cfg c;
        wait_idle();
        c = default_cfg();
        c.layout   = qmr_pkg::LAY_CHLAST;
        c.channels = '1;
        configure(c, 1'b0);
        repeat (12) elem(8'd1, 8'h00);
        wait_idle();
        c.layout     = qmr_pkg::LAY_CHMAJ;
        c.channels   = qmr_pkg::CHCNT_W'(2);
        c.inner_size = '1;
        configure(c, 1'b0);
        repeat (6) elem(8'($urandom()), 8'h00);
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        qmr_pkg::t_cfg c;
        wait_idle();
        c = default_cfg();
        c.scale = 32'd1 << 20;
        configure(c, 1'b0);
        tx_gap_max = 0;
        hold_asked++;
        repeat (60) elem(8'($urandom()), 8'($urandom()));
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic qmr_pkg::t_cfg rand_cfg();
        qmr_pkg::t_cfg c;
        c.layout      = 2'($urandom_range(0, 3));
        c.data_signed = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       c.scale = 32'd1 << (qmr_pkg::SCALE_FRAC_BITS - 1);
            1:       c.scale = 32'd1 << (qmr_pkg::SCALE_FRAC_BITS - 2);
            2:       c.scale = $urandom();
            3:       c.scale = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
            default: c.scale = $urandom_range(0, 32'h0010_0000);
        endcase
        c.a_zero = ($urandom_range(0, 3) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 383) - 128);
        c.b_zero = ($urandom_range(0, 3) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 383) - 128);
        c.y_zero = ($urandom_range(0, 3) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 383) - 128);
        c.channels   = ($urandom_range(0, 5) == 0) ? qmr_pkg::CHCNT_W'($urandom_range(13, 8191))
                                                   : qmr_pkg::CHCNT_W'($urandom_range(0, 12));
        c.inner_size = ($urandom_range(0, 7) == 0) ? qmr_pkg::INNER_CFG_W'($urandom())
                                                   : qmr_pkg::INNER_CFG_W'($urandom_range(0, 6));
        return c;
    endfunction

    // Random phases: new settings, then a mixed stream of elements and loads
    task automatic test_random();
        int sent;
        int len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            configure(rand_cfg(), 1'($urandom_range(0, 1)));
            n_phases++;
            case ($urandom_range(0, 2))
                0:       tx_gap_max = 0;
                1:       tx_gap_max = 3;
                default: tx_gap_max = 10;
            endcase
            rx_stall_en = ($urandom_range(0, 3) != 0);
            len = $urandom_range(20, PHASE_MAX);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 7) == 0)
                    issue_item(qmr_pkg::REQ_LOAD, rand_byte(), rand_byte(), 12'($urandom()));
                else
                    issue_item(qmr_pkg::REQ_ELEM, rand_byte(), rand_byte(), 12'($urandom()));
                sent++;
            end
        end
    endtask

    initial begin
        cur       = default_cfg();
        inner_pos = 0;
        chan_pos  = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_table_fill();
        test_round_clamp();
        test_layouts();
        test_channel_limit();
        test_backpressure();
        rx_stall_en = 1'b1;
        tx_gap_max  = 6;
        test_random();

        wait_idle();
        if (pending_y.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, pending_y.size());
        $display("checked %0d results over %0d table loads and %0d register writes,",
                 n_checked, n_loads, n_writes);
        $display("all three layouts, both signednesses and %0d random settings", n_phases);
        if (errors == 0 && pending_y.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #10ms;
        $display("%0t: run did not complete in time", $time);
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/qmr_pkg.sv
hw/rtl/qmr_chan.sv
hw/rtl/qmr_math.sv
hw/rtl/quantized_multiply_requantize_top.sv
tb/tb_quantized_multiply_requantize_top.sv
